[rtl/plm_pkg.sv]
// ---------------------------------------------------------------------------
// plm_pkg: shared types and constants for the piecewise linear map
// Point widths, table sizes, register indexes and the stage payload structs.
// ---------------------------------------------------------------------------
package plm_pkg;

  localparam int POINT_W    = 16;
  localparam int MAX_POINTS = 12;
  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int K_W        = 4;
  localparam int PROD_W     = 2 * POINT_W;

  // register indexes: three words of input points, then three of output points
  localparam logic [CFG_IDX_W-1:0] REG_IN_0_3  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_0_3 = 3'd3;

  // quotient bits resolved per divider stage
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = POINT_W / DIV_STEPS;

  typedef logic [MAX_POINTS-1:0][POINT_W-1:0] point_arr_t;

  typedef enum logic [1:0] {
    SEL_INTERP = 2'd0,
    SEL_FIRST  = 2'd1,
    SEL_LAST   = 2'd2
  } sel_t;

  typedef struct packed {
    logic [POINT_W-1:0] value;
    logic [K_W-1:0]     k;
    sel_t               sel;
    logic               incr;
  } bracket_t;

  typedef struct packed {
    logic [POINT_W-1:0] dv;
    logic [POINT_W-1:0] di;
    logic [POINT_W-1:0] dout;
    logic               neg;
    logic [POINT_W-1:0] base;
  } operand_t;

  typedef struct packed {
    logic [POINT_W-1:0] rem;
    logic [POINT_W-1:0] low;
    logic [POINT_W-1:0] quo;
    logic [POINT_W-1:0] di;
    logic               neg;
    logic [POINT_W-1:0] base;
  } div_t;

endpackage

[rtl/piecewise_linear_map.sv]
// ---------------------------------------------------------------------------
// piecewise_linear_map: piecewise linear interpolation through a point table
// Maps a 16-bit reading through MAP_SIZE configured breakpoint pairs.
// ---------------------------------------------------------------------------
// Each reading flows through an eight-stage pipeline: bin search, operand
// fetch, 16x16 multiply, four divider stages of four quotient bits each, and
// the final add, each registered. One reading is accepted per clock while the
// output is not stalled; a stall at the output holds only the stages that are
// full, so empty stages still fill. The breakpoint tables are six 64-bit
// registers written through the cfg port, four 16-bit points to a word, and
// they must be written only while no reading is in flight. Below an
// increasing table, or above a decreasing one, the result is the first output
// point; with no bracketing bin it is the last.
module piecewise_linear_map #(
  parameter int MAP_SIZE = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             value_valid,
  output logic                             value_ready,
  input  logic [plm_pkg::POINT_W-1:0]      value,
  output logic                             mapped_valid,
  input  logic                             mapped_ready,
  output logic [plm_pkg::POINT_W-1:0]      mapped,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [plm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NDIV = plm_pkg::DIV_STAGES;

  logic [plm_pkg::CFG_DATA_W-1:0] cfg_regs [plm_pkg::NUM_REGS];
  plm_pkg::point_arr_t            in_pts;
  plm_pkg::point_arr_t            out_pts;

  logic              br_valid;
  plm_pkg::bracket_t br_data;
  logic              op_valid;
  plm_pkg::operand_t op_data;

  // index 0 is the multiply register, 1..NDIV the divider stages
  logic [NDIV:0]     div_valid;
  plm_pkg::div_t     div_data [NDIV+1];
  plm_pkg::div_t     mul_next;
  logic              mul_valid;
  plm_pkg::div_t     mul_data;
  logic [plm_pkg::PROD_W-1:0] prod;

  logic              ready_out;
  logic [NDIV:0]     div_ready;
  logic              op_ready;
  logic              br_ready;
  logic [plm_pkg::POINT_W-1:0] mapped_next;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < plm_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < plm_pkg::CFG_IDX_W'(plm_pkg::NUM_REGS)) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  for (genvar j = 0; j < plm_pkg::MAX_POINTS; j++) begin : g_unpack
    assign in_pts[j]  = cfg_regs[int'(plm_pkg::REG_IN_0_3) + j / 4]
                                [(j % 4) * plm_pkg::POINT_W +: plm_pkg::POINT_W];
    assign out_pts[j] = cfg_regs[int'(plm_pkg::REG_OUT_0_3) + j / 4]
                                [(j % 4) * plm_pkg::POINT_W +: plm_pkg::POINT_W];
  end

  // stage ready chain: a stage takes new data when empty or moving on
  assign ready_out = !mapped_valid || mapped_ready;
  for (genvar g = 0; g <= NDIV; g++) begin : g_ready
    if (g == NDIV) begin : g_last
      assign div_ready[g] = !div_valid[g] || ready_out;
    end else begin : g_mid
      assign div_ready[g] = !div_valid[g] || div_ready[g+1];
    end
  end
  assign op_ready    = !op_valid || div_ready[0];
  assign br_ready    = !br_valid || op_ready;
  assign value_ready = br_ready;

  plm_bracket #(
    .MAP_SIZE (MAP_SIZE)
  ) u_bracket (
    .clk      (clk),
    .rst      (rst),
    .load     (br_ready),
    .valid_in (value_valid),
    .value    (value),
    .in_pts   (in_pts),
    .valid    (br_valid),
    .data     (br_data)
  );

  plm_diff #(
    .MAP_SIZE (MAP_SIZE)
  ) u_diff (
    .clk      (clk),
    .rst      (rst),
    .load     (op_ready),
    .valid_in (br_valid),
    .br       (br_data),
    .in_pts   (in_pts),
    .out_pts  (out_pts),
    .valid    (op_valid),
    .data     (op_data)
  );

  // multiply stage: product of magnitudes, below di * 2^16
  always_comb begin
    prod          = {{plm_pkg::POINT_W{1'b0}}, op_data.dv}
                  * {{plm_pkg::POINT_W{1'b0}}, op_data.dout};
    mul_next.rem  = prod[plm_pkg::PROD_W-1:plm_pkg::POINT_W];
    mul_next.low  = prod[plm_pkg::POINT_W-1:0];
    mul_next.quo  = '0;
    mul_next.di   = op_data.di;
    mul_next.neg  = op_data.neg;
    mul_next.base = op_data.base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (div_ready[0]) begin
      mul_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready[0]) begin
      mul_data <= mul_next;
    end
  end

  assign div_valid[0] = mul_valid;
  assign div_data[0]  = mul_data;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    plm_div_stage #(
      .STEPS (plm_pkg::DIV_STEPS)
    ) u_div_stage (
      .clk      (clk),
      .rst      (rst),
      .load     (div_ready[g+1]),
      .valid_in (div_valid[g]),
      .d_in     (div_data[g]),
      .valid    (div_valid[g+1]),
      .data     (div_data[g+1])
    );
  end

  // output stage: apply the slope sign to the truncated quotient
  assign mapped_next = div_data[NDIV].neg ? (div_data[NDIV].base - div_data[NDIV].quo)
                                          : (div_data[NDIV].base + div_data[NDIV].quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      mapped_valid <= 1'b0;
    end else if (ready_out) begin
      mapped_valid <= div_valid[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out) begin
      mapped <= mapped_next;
    end
  end

endmodule

[rtl/plm_bracket.sv]
// ---------------------------------------------------------------------------
// plm_bracket: direction test and bin search
// Compares the value against every breakpoint in parallel and registers the
// first bracketing bin, or which end point to clamp to.
// ---------------------------------------------------------------------------
module plm_bracket #(
  parameter int MAP_SIZE = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic                                valid_in,
  input  logic [plm_pkg::POINT_W-1:0]         value,
  input  plm_pkg::point_arr_t                 in_pts,
  output logic                                valid,
  output plm_pkg::bracket_t                   data
);

  localparam int LAST = MAP_SIZE - 1;

  plm_pkg::bracket_t data_next;
  logic              incr;
  logic              below;
  logic              hit;
  logic              found;
  logic [plm_pkg::K_W-1:0] k;

  always_comb begin
    incr  = in_pts[LAST] > in_pts[0];
    below = incr ? (value < in_pts[0]) : (value > in_pts[0]);
    hit   = 1'b0;
    found = 1'b0;
    k     = '0;
    // walk downward so the lowest matching bin wins
    for (int j = LAST - 1; j >= 0; j--) begin
      hit = incr ? (value >= in_pts[j] && value < in_pts[j+1])
                 : (value < in_pts[j] && value >= in_pts[j+1]);
      if (hit) begin
        found = 1'b1;
        k     = plm_pkg::K_W'(j);
      end
    end
    data_next.value = value;
    data_next.k     = k;
    data_next.incr  = incr;
    if (below) begin
      data_next.sel = plm_pkg::SEL_FIRST;
    end else if (found) begin
      data_next.sel = plm_pkg::SEL_INTERP;
    end else begin
      data_next.sel = plm_pkg::SEL_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

[rtl/plm_diff.sv]
// ---------------------------------------------------------------------------
// plm_diff: bin operand fetch
// Picks the two points of the chosen bin and forms the distance magnitudes,
// the output slope sign and the base value; clamps become a zero offset.
// ---------------------------------------------------------------------------
module plm_diff #(
  parameter int MAP_SIZE = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 valid_in,
  input  plm_pkg::bracket_t    br,
  input  plm_pkg::point_arr_t  in_pts,
  input  plm_pkg::point_arr_t  out_pts,
  output logic                 valid,
  output plm_pkg::operand_t    data
);

  localparam int LAST = MAP_SIZE - 1;

  plm_pkg::operand_t          data_next;
  logic [plm_pkg::K_W-1:0]     kn;
  logic [plm_pkg::POINT_W-1:0] a;
  logic [plm_pkg::POINT_W-1:0] b;
  logic [plm_pkg::POINT_W-1:0] oa;
  logic [plm_pkg::POINT_W-1:0] ob;

  always_comb begin
    kn = br.k + plm_pkg::K_W'(1);
    a  = in_pts[br.k];
    b  = in_pts[kn];
    oa = out_pts[br.k];
    ob = out_pts[kn];
    // clamp cases: zero offset, unit divisor
    data_next.dv   = '0;
    data_next.di   = plm_pkg::POINT_W'(1);
    data_next.dout = '0;
    data_next.neg  = 1'b0;
    data_next.base = out_pts[LAST];
    case (br.sel)
      plm_pkg::SEL_INTERP: begin
        // both distances share a sign, so work on magnitudes
        data_next.dv   = br.incr ? (br.value - a) : (a - br.value);
        data_next.di   = br.incr ? (b - a) : (a - b);
        data_next.neg  = ob < oa;
        data_next.dout = (ob < oa) ? (oa - ob) : (ob - oa);
        data_next.base = oa;
      end
      plm_pkg::SEL_FIRST: begin
        data_next.base = out_pts[0];
      end
      plm_pkg::SEL_LAST: begin
        data_next.base = out_pts[LAST];
      end
      default: begin
        data_next.base = out_pts[LAST];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

[rtl/plm_div_stage.sv]
// ---------------------------------------------------------------------------
// plm_div_stage: one stage of the restoring divider
// Resolves STEPS quotient bits of the unsigned product divided by the bin
// width and registers the partial remainder and quotient.
// ---------------------------------------------------------------------------
module plm_div_stage #(
  parameter int STEPS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          valid_in,
  input  plm_pkg::div_t d_in,
  output logic          valid,
  output plm_pkg::div_t data
);

  plm_pkg::div_t                 w;
  logic [plm_pkg::POINT_W:0]     t;
  logic [plm_pkg::POINT_W:0]     sub;

  always_comb begin
    w   = d_in;
    t   = '0;
    sub = '0;
    for (int s = 0; s < STEPS; s++) begin
      t   = {w.rem, w.low[plm_pkg::POINT_W-1]};
      sub = t - {1'b0, w.di};
      // remainder stays below the divisor, so it fits back in POINT_W bits
      if (t >= {1'b0, w.di}) begin
        w.rem = sub[plm_pkg::POINT_W-1:0];
        w.quo = {w.quo[plm_pkg::POINT_W-2:0], 1'b1};
      end else begin
        w.rem = t[plm_pkg::POINT_W-1:0];
        w.quo = {w.quo[plm_pkg::POINT_W-2:0], 1'b0};
      end
      w.low = {w.low[plm_pkg::POINT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= w;
    end
  end

endmodule

[tb/sv/tb_piecewise_linear_map.sv]
// ---------------------------------------------------------------------------
// tb_piecewise_linear_map: self-checking bench for the piecewise linear map
// Loads rising, falling, jumbled, full-swing, saturated and stepped point
// tables, streams readings under random idling and back-pressure, and checks
// every mapped value against a typed expectation or a behavioral predictor.
// ---------------------------------------------------------------------------
module tb_piecewise_linear_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_SIZE        = 9;
  localparam int PIPE_DEPTH      = 8;
  localparam int READINGS_PER_TABLE = 140;
  localparam int HOLD_CYCLES     = 300;
  localparam int N_ROWS          = 33;

  localparam logic [plm_pkg::CFG_IDX_W-1:0] REG_IN_4_7   = plm_pkg::REG_IN_0_3 + 3'd1;
  localparam logic [plm_pkg::CFG_IDX_W-1:0] REG_IN_8_11  = plm_pkg::REG_IN_0_3 + 3'd2;
  localparam logic [plm_pkg::CFG_IDX_W-1:0] REG_OUT_4_7  = plm_pkg::REG_OUT_0_3 + 3'd1;
  localparam logic [plm_pkg::CFG_IDX_W-1:0] REG_OUT_8_11 = plm_pkg::REG_OUT_0_3 + 3'd2;
  // indexes past the last register, writes there must be dropped
  localparam logic [plm_pkg::CFG_IDX_W-1:0] REG_SPARE_6  = 3'd6;
  localparam logic [plm_pkg::CFG_IDX_W-1:0] REG_SPARE_7  = 3'd7;

  typedef enum logic {ROW_VALUE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [plm_pkg::CFG_IDX_W-1:0]   index;
    logic [plm_pkg::CFG_DATA_W-1:0]  data;
    logic [plm_pkg::POINT_W-1:0]     reading;
    logic                            typed;
    logic [plm_pkg::POINT_W-1:0]     want;
  } step_row_t;

  typedef struct {
    logic [plm_pkg::POINT_W-1:0] reading;
    logic [plm_pkg::POINT_W-1:0] mapped;
  } due_t;

  typedef enum int {
    SHAPE_RISING, SHAPE_FALLING, SHAPE_JUMBLED, SHAPE_SWING_UP,
    SHAPE_SWING_DOWN, SHAPE_SATURATED, SHAPE_STEPPED
  } shape_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            value_valid;
  logic                            value_ready;
  logic [plm_pkg::POINT_W-1:0]     value;
  logic                            mapped_valid;
  logic                            mapped_ready = 1'b0;
  logic [plm_pkg::POINT_W-1:0]     mapped;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [plm_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [plm_pkg::CFG_DATA_W-1:0]  cfg_data;

  // sideband that travels with each reading: a hand-typed expectation
  logic                            row_has_expect;
  logic [plm_pkg::POINT_W-1:0]     row_expect;

  logic [plm_pkg::CFG_DATA_W-1:0]  point_words [plm_pkg::NUM_REGS];
  due_t                   mapped_due [$];
  due_t                   head_due;
  due_t                   new_due;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit pressure_go   = 1'b0;
  logic hold_off    = 1'b0;

  int readings_sent   = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int stall_cycles    = 0;
  int setups_loaded   = 1;

  shape_t phase_shape [7] = '{SHAPE_RISING, SHAPE_FALLING, SHAPE_JUMBLED, SHAPE_SWING_UP,
                              SHAPE_SWING_DOWN, SHAPE_SATURATED, SHAPE_STEPPED};

  step_row_t directed_rows [N_ROWS] = '{
    // all-zero table after reset maps everything to zero
    '{ROW_VALUE, '0,           64'h0,                   16'd0,     1'b1, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd65535, 1'b1, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd12345, 1'b1, 16'd0},
    // rising table, junk above the last point
    '{ROW_CFG, plm_pkg::REG_IN_0_3,  64'h1388_07D0_03E8_0064, 16'd0, 1'b0, 16'd0},
    '{ROW_CFG,   REG_IN_4_7,   64'hEA60_9C40_4E20_2710, 16'd0,     1'b0, 16'd0},
    '{ROW_CFG,   REG_IN_8_11,  64'hFFFF_1234_0000_FDE8, 16'd0,     1'b0, 16'd0},
    '{ROW_CFG, plm_pkg::REG_OUT_0_3, 64'h7530_7530_FFFF_0000, 16'd0, 1'b0, 16'd0},
    '{ROW_CFG,   REG_OUT_4_7,  64'hFFFF_0001_C350_3039, 16'd0,     1'b0, 16'd0},
    '{ROW_CFG,   REG_OUT_8_11, 64'hABCD_0000_5555_0007, 16'd0,     1'b0, 16'd0},
    '{ROW_CFG,   REG_SPARE_6,  64'hFFFF_FFFF_FFFF_FFFF, 16'd0,     1'b0, 16'd0},
    '{ROW_CFG,   REG_SPARE_7,  64'h5A5A_A5A5_0F0F_F0F0, 16'd0,     1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd0,     1'b1, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd99,    1'b1, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd100,   1'b1, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd999,   1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd1000,  1'b1, 16'd65535},
    '{ROW_VALUE, '0,           64'h0,                   16'd3500,  1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd7500,  1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd30000, 1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd64999, 1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd65000, 1'b1, 16'd7},
    '{ROW_VALUE, '0,           64'h0,                   16'd65535, 1'b1, 16'd7},
    // falling table with a flat bin in the middle
    '{ROW_CFG, plm_pkg::REG_IN_0_3,  64'h9C40_9C40_C350_EA60, 16'd0, 1'b0, 16'd0},
    '{ROW_CFG,   REG_IN_4_7,   64'h0001_1388_2710_7530, 16'd0,     1'b0, 16'd0},
    '{ROW_CFG,   REG_IN_8_11,  64'h1111_2222_3333_0000, 16'd0,     1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd65535, 1'b1, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd60001, 1'b1, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd60000, 1'b1, 16'd7},
    '{ROW_VALUE, '0,           64'h0,                   16'd59999, 1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd40000, 1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd35000, 1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd1,     1'b0, 16'd0},
    '{ROW_VALUE, '0,           64'h0,                   16'd0,     1'b0, 16'd0}
  };

  piecewise_linear_map #(
    .MAP_SIZE(MAP_SIZE)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .value_valid(value_valid),
    .value_ready(value_ready),
    .value(value),
    .mapped_valid(mapped_valid),
    .mapped_ready(mapped_ready),
    .mapped(mapped),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint in_point(input int j);
    return longint'(point_words[plm_pkg::REG_IN_0_3 + j / 4]
                               [(j % 4) * plm_pkg::POINT_W +: plm_pkg::POINT_W]);
  endfunction

  function automatic longint out_point(input int j);
    return longint'(point_words[plm_pkg::REG_OUT_0_3 + j / 4]
                               [(j % 4) * plm_pkg::POINT_W +: plm_pkg::POINT_W]);
  endfunction

  function automatic logic [plm_pkg::POINT_W-1:0] predict_mapped(
      input logic [plm_pkg::POINT_W-1:0] reading);
    longint x;
    longint a;
    longint b;
    longint res;
    bit rising;
    int k;
    x = longint'(reading);
    rising = in_point(0) < in_point(MAP_SIZE - 1);
    if (rising ? (x < in_point(0)) : (x > in_point(0))) begin
      res = out_point(0);
      return res[plm_pkg::POINT_W-1:0];
    end
    for (k = 0; k < MAP_SIZE - 1; k++) begin
      a = in_point(k);
      b = in_point(k + 1);
      if (rising ? (x >= a && x < b) : (x < a && x >= b)) begin
        // exact product, division truncates toward zero
        res = out_point(k) + ((x - a) * (out_point(k + 1) - out_point(k))) / (b - a);
        return res[plm_pkg::POINT_W-1:0];
      end
    end
    res = out_point(MAP_SIZE - 1);
    return res[plm_pkg::POINT_W-1:0];
  endfunction

  function automatic logic [plm_pkg::POINT_W-1:0] pick_reading();
    logic [plm_pkg::POINT_W-1:0] r;
    longint near;
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) begin
      near = in_point($urandom_range(0, MAP_SIZE - 1)) + longint'($urandom_range(0, 4)) - 2;
      r = near[plm_pkg::POINT_W-1:0];
    end else if (roll < 55) begin
      r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      r = plm_pkg::POINT_W'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  task automatic send_value(input logic [plm_pkg::POINT_W-1:0] v, input logic typed,
                            input logic [plm_pkg::POINT_W-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      value_valid <= 1'b0;
      @(posedge clk);
    end
    value_valid    <= 1'b1;
    value          <= v;
    row_has_expect <= typed;
    row_expect     <= want;
    @(posedge clk);
    while (!value_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [plm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [plm_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // table writes are only legal with nothing in flight
  task automatic settle_pipeline();
    value_valid <= 1'b0;
    @(posedge clk);
    while (mapped_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic program_table(input shape_t shape);
    int pin [12];
    int pout [12];
    int i;
    int j;
    int t;
    logic [plm_pkg::CFG_DATA_W-1:0] w;
    for (j = 0; j < 12; j++) begin
      pin[j]  = $urandom_range(0, 65535);
      pout[j] = $urandom_range(0, 65535);
    end
    case (shape)
      SHAPE_STEPPED: begin
        for (j = 0; j < MAP_SIZE; j++) pin[j] = $urandom_range(0, 7) * 8192;
      end
      SHAPE_SWING_UP, SHAPE_SWING_DOWN: begin
        for (j = 0; j < MAP_SIZE; j++) begin
          pin[j]  = $urandom_range(2, 65534);
          pout[j] = (j % 2) ? 65535 : 0;
        end
      end
      SHAPE_SATURATED: begin
        for (j = 0; j < 12; j++) begin
          pin[j]  = 65535;
          pout[j] = 65535;
        end
      end
      default: begin
      end
    endcase
    if (shape != SHAPE_JUMBLED && shape != SHAPE_SATURATED) begin
      for (i = 0; i < MAP_SIZE; i++) begin
        for (j = 0; j < MAP_SIZE - 1 - i; j++) begin
          if (pin[j] > pin[j + 1]) begin
            t = pin[j];
            pin[j] = pin[j + 1];
            pin[j + 1] = t;
          end
        end
      end
    end
    if (shape == SHAPE_SWING_UP || shape == SHAPE_SWING_DOWN) begin
      // full input range with a one-count first bin
      pin[0] = 0;
      pin[1] = 1;
      pin[MAP_SIZE - 1] = 65535;
    end
    if (shape == SHAPE_FALLING || shape == SHAPE_SWING_DOWN) begin
      for (j = 0; j < MAP_SIZE / 2; j++) begin
        t = pin[j];
        pin[j] = pin[MAP_SIZE - 1 - j];
        pin[MAP_SIZE - 1 - j] = t;
      end
    end
    settle_pipeline();
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 4; j++) w[16 * j +: 16] = pin[4 * i + j][15:0];
      write_reg(plm_pkg::CFG_IDX_W'(plm_pkg::REG_IN_0_3 + i), w);
      for (j = 0; j < 4; j++) w[16 * j +: 16] = pout[4 * i + j][15:0];
      write_reg(plm_pkg::CFG_IDX_W'(plm_pkg::REG_OUT_0_3 + i), w);
    end
    write_reg($urandom_range(0, 1) ? REG_SPARE_7 : REG_SPARE_6, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    setups_loaded++;
  endtask

  always @(posedge clk) begin
    mapped_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // long output stall so the pipeline fills and pushes back on the input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready && cfg_index < plm_pkg::NUM_REGS) begin
        point_words[cfg_index] = cfg_data;
      end
      if (value_valid && !value_ready) stall_cycles++;
      if (mapped_valid && mapped_ready) begin
        if (mapped_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result %h with no reading outstanding", mapped);
          end
        end else begin
          head_due = mapped_due.pop_front();
          results_checked++;
          if (mapped !== head_due.mapped) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("reading %h: mapped expected %h got %h",
                       head_due.reading, head_due.mapped, mapped);
            end
          end
        end
      end
      if (value_valid && value_ready) begin
        new_due.reading = value;
        new_due.mapped  = row_has_expect ? row_expect : predict_mapped(value);
        mapped_due.push_back(new_due);
        readings_sent++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("piecewise_linear_map: mismatch");
    $finish;
  end

  initial begin
    int i;
    int ph;
    int n;
    for (i = 0; i < plm_pkg::NUM_REGS; i++) point_words[i] = '0;
    rst            <= 1'b1;
    value_valid    <= 1'b0;
    value          <= '0;
    row_has_expect <= 1'b0;
    row_expect     <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= plm_pkg::REG_IN_0_3;
    cfg_data       <= '0;
    send_idle_pct = 16;
    recv_idle_pct = 55;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i == 0 || directed_rows[i - 1].kind == ROW_VALUE) begin
          settle_pipeline();
          setups_loaded++;
        end
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        cfg_valid <= 1'b0;
        send_value(directed_rows[i].reading, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (ph = 0; ph < 7; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 55;
      end else if (ph < 5) begin
        send_idle_pct = 55;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_table(phase_shape[ph]);
      if (ph == 6) pressure_go = 1'b1;
      for (n = 0; n < READINGS_PER_TABLE; n++) send_value(pick_reading(), 1'b0, '0);
    end

    settle_pipeline();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mapped_due.size() != 0) begin
      $display("%0d expected results never arrived", mapped_due.size());
      mismatch_count += mapped_due.size();
    end
    $display("covered %0d readings over %0d point tables, %0d results compared",
             readings_sent, setups_loaded, results_checked);
    $display("input stalled by back-pressure for %0d cycles, %0d mismatches",
             stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("piecewise_linear_map: match");
    end else begin
      $display("piecewise_linear_map: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/plm_pkg.sv
rtl/plm_bracket.sv
rtl/plm_diff.sv
rtl/plm_div_stage.sv
rtl/piecewise_linear_map.sv
tb/sv/tb_piecewise_linear_map.sv
